/* src/sorted_insert_queue_with_rollback_assert.svh */
// ----------------------------------------------------------------------------
// sorted insert queue assertion macros
// concurrent assertion helpers shared by the queue top level
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_QUEUE_WITH_ROLLBACK_ASSERT_SVH
`define SORTED_INSERT_QUEUE_WITH_ROLLBACK_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SIQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// antecedent implies consequent in the next cycle
`define SIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

/* src/siq_pkg.sv */
// ----------------------------------------------------------------------------
// siq_pkg
// shared types, codes and bus layout of the sorted insert queue
// ----------------------------------------------------------------------------
package siq_pkg;

    localparam int DEF_QUEUE_DEPTH = 256;

    localparam int KIND_W = 3;
    localparam int STATUS_W = 2;
    localparam int RIDX_W = 9;
    localparam int POS_W = 8;
    localparam int IN_TDATA_W = 200;
    localparam int OUT_TDATA_W = 216;

    // transaction kinds
    localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BACKUP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESTORE = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // read address select
    localparam logic [1:0] RD_HEAD = 2'd0;
    localparam logic [1:0] RD_POS_M1 = 2'd1;
    localparam logic [1:0] RD_POS_M2 = 2'd2;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] payload;
        logic [31:0] key;
        logic [15:0] rule;
    } t_entry;

    typedef struct packed {
        logic       cap;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       shift;
        logic       ins;
        logic       grab;
        logic       upd;
        logic       load;
    } t_cmd;

    typedef struct packed {
        logic is_push;
        logic is_rd;
        logic full;
        logic empty;
        logic sorted;
        logic can_scan;
        logic scan_more;
        logic key_gt;
        logic out_busy;
    } t_sts;

endpackage

/* src/siq_ctrl.sv */
// ----------------------------------------------------------------------------
// siq_ctrl
// sequencer for one queue transaction at a time: decode, key scan, insert,
// head read, state update and hand-off to the output register
// ----------------------------------------------------------------------------
module siq_ctrl
    import siq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_INS = 3'd3;
    localparam logic [2:0] S_RDW = 3'd4;
    localparam logic [2:0] S_UPD = 3'd5;
    localparam logic [2:0] S_FIN = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_push) begin
                    if (i_sts.full) begin
                        n_state = S_UPD;
                    end else if (i_sts.sorted && i_sts.can_scan) begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rd_sel = RD_POS_M1;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_INS;
                    end
                end else if (i_sts.is_rd) begin
                    if (i_sts.empty) begin
                        n_state = S_UPD;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rd_sel = RD_HEAD;
                        n_state = S_RDW;
                    end
                end else begin
                    n_state = S_UPD;
                end
            end
            S_SCAN: begin
                if (i_sts.key_gt) begin
                    o_cmd.shift = 1'b1;
                    if (i_sts.scan_more) begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rd_sel = RD_POS_M2;
                    end else begin
                        n_state = S_INS;
                    end
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state = S_UPD;
            end
            S_RDW: begin
                o_cmd.grab = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* src/siq_dp.sv */
// ----------------------------------------------------------------------------
// siq_dp
// entry memory, queue indices, pop bookkeeping, input capture and the
// output register of the sorted insert queue
// ----------------------------------------------------------------------------
module siq_dp
    import siq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic [KIND_W-1:0]      i_in_kind,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic [STATUS_W-1:0]    o_out_status,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts
);

    localparam int IW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [IW-1:0] LP_DEPTH = IW'(QUEUE_DEPTH);

    t_entry mem [QUEUE_DEPTH];
    t_entry r_rd_data;
    t_entry r_ent;
    t_entry w_new;

    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic [IW-1:0] r_pos;
    logic [31:0]   r_last_step;
    logic [31:0]   r_pop_count;
    logic          r_sorted;

    logic [KIND_W-1:0] r_kind;
    logic [15:0]       r_rule;
    logic [31:0]       r_key;
    logic [31:0]       r_payload;
    logic [31:0]       r_step;
    logic [RIDX_W-1:0] r_rs_head;
    logic [RIDX_W-1:0] r_rs_tail;
    logic [31:0]       r_rs_last;
    logic [31:0]       r_rs_count;

    logic [STATUS_W-1:0] r_status;
    logic                r_has;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [STATUS_W-1:0]    r_out_status;

    logic [AW-1:0] w_rd_addr;
    logic          w_full;
    logic          w_empty;
    logic          w_is_push;
    logic          w_is_rd;
    logic [IW-1:0] w_rs_head;
    logic [IW-1:0] w_rs_tail;
    logic [IW-1:0] w_occ;
    t_entry        w_out_ent;

    assign w_new = '{stamp: r_step, payload: r_payload, key: r_key, rule: r_rule};
    assign w_full = (r_tail >= LP_DEPTH);
    assign w_empty = (r_head >= r_tail) || (r_head >= LP_DEPTH);
    assign w_is_push = (r_kind == KIND_PUSH);
    assign w_is_rd = r_kind inside {KIND_POP, KIND_PEEK};

    assign w_rs_head = (32'(r_rs_head) > 32'(QUEUE_DEPTH)) ? LP_DEPTH : IW'(r_rs_head);
    assign w_rs_tail = (32'(r_rs_tail) > 32'(QUEUE_DEPTH)) ? LP_DEPTH : IW'(r_rs_tail);
    assign w_occ = (r_tail > r_head) ? (r_tail - r_head) : '0;
    assign w_out_ent = r_has ? r_ent : '0;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_HEAD:   w_rd_addr = AW'(r_head);
            RD_POS_M1: w_rd_addr = AW'(r_pos - IW'(1));
            RD_POS_M2: w_rd_addr = AW'(r_pos - IW'(2));
            default:   w_rd_addr = AW'(r_head);
        endcase
    end

    always_comb begin
        o_sts.is_push = w_is_push;
        o_sts.is_rd = w_is_rd;
        o_sts.full = w_full;
        o_sts.empty = w_empty;
        o_sts.sorted = r_sorted;
        o_sts.can_scan = (r_pos > r_head);
        o_sts.scan_more = ({1'b0, r_pos} > ({1'b0, r_head} + (IW + 1)'(1)));
        o_sts.key_gt = (r_rd_data.key > r_key);
        o_sts.out_busy = r_out_valid && !i_out_ready;
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            mem[AW'(r_pos)] <= r_rd_data;
        end else if (i_cmd.ins) begin
            mem[AW'(r_pos)] <= w_new;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    // input capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind <= i_in_kind;
            r_rule <= i_in_data[15:0];
            r_key <= i_in_data[47:16];
            r_payload <= i_in_data[79:48];
            r_step <= i_in_data[111:80];
            r_rs_head <= i_in_data[120:112];
            r_rs_tail <= i_in_data[129:121];
            r_rs_last <= i_in_data[161:130];
            r_rs_count <= i_in_data[193:162];
            r_pos <= (i_in_kind == KIND_PUSH) ? r_tail : r_head;
        end else if (i_cmd.shift) begin
            r_pos <= r_pos - IW'(1);
        end
        if (i_cmd.ins) begin
            r_ent <= w_new;
        end else if (i_cmd.grab) begin
            r_ent <= r_rd_data;
        end
        if (i_cmd.upd) begin
            r_status <= ST_OK;
            r_has <= 1'b0;
            if (w_is_push) begin
                r_status <= w_full ? ST_FULL : ST_OK;
                r_has <= !w_full;
            end else if (w_is_rd) begin
                r_status <= w_empty ? ST_EMPTY : ST_OK;
                r_has <= !w_empty;
            end
        end
    end

    // queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_last_step <= '0;
            r_pop_count <= '0;
            r_sorted <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_sorted <= i_cfg_wr_data;
            end
            if (i_cmd.upd) begin
                if (w_is_push) begin
                    if (!w_full) begin
                        r_tail <= r_tail + IW'(1);
                    end
                end else if (r_kind == KIND_POP) begin
                    if (!w_empty) begin
                        r_head <= r_head + IW'(1);
                        r_pop_count <= r_pop_count + 32'd1;
                        r_last_step <= r_step;
                    end
                end else if (r_kind == KIND_RESTORE) begin
                    r_head <= w_rs_head;
                    r_tail <= w_rs_tail;
                    r_last_step <= r_rs_last;
                    r_pop_count <= r_rs_count;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status <= r_status;
            r_out_data <= {5'd0,
                           r_pop_count,
                           r_last_step,
                           RIDX_W'(w_occ),
                           RIDX_W'(r_tail),
                           RIDX_W'(r_head),
                           w_out_ent.stamp,
                           w_out_ent.payload,
                           w_out_ent.key,
                           w_out_ent.rule,
                           r_has ? POS_W'(r_pos) : POS_W'(0)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;
    assign o_out_status = r_out_status;

endmodule

/* src/sorted_insert_queue_with_rollback.sv */
// ----------------------------------------------------------------------------
// sorted_insert_queue_with_rollback
// entry queue with optional key-ordered insert and head/tail rollback
// ----------------------------------------------------------------------------
// usage: one command transaction enters on s_axis, one result transaction
// leaves on m_axis for every command. the command kind rides on s_axis_tuser
// and the result status on m_axis_tuser. i_cfg_wr_en/i_cfg_wr_data set the
// sorted insert mode; the user must write them only while the queue is idle,
// as the block does not enforce this. one transaction is in flight at a time.
// backup, restore and refused commands go from decode to the state update;
// pop and peek read the head; push appends at the tail, or in sorted mode
// scans down from the tail and moves each stored entry whose key exceeds the
// new key up one place (reading and moving one entry per cycle through the
// single memory read port) before the new entry goes in. the result turns
// valid in the same cycle that s_axis_tready returns high.
// after reset head, tail, last step and pop count are zero, sorted mode is
// on and the entry memory holds no defined contents; no clearing pass runs.
// when the receiver stalls the result waits in the output register; the
// next command is still taken and worked on, and holds at its last step
// until the output register is free.
// ----------------------------------------------------------------------------
module sorted_insert_queue_with_rollback
    import siq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // rule_id, sort_key, entry_payload, step, restore_head, restore_tail,
    // restore_last_step, restore_count, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // position, out_rule_id, out_key, out_payload, out_stamp, head_index,
    // tail_index, occupancy, last_step, pop_count, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    t_cmd w_cmd;
    t_sts w_sts;

    siq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    siq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (s_axis_tdata),
        .i_in_kind     (s_axis_tuser),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_status  (m_axis_tuser),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

`include "sorted_insert_queue_with_rollback_assert.svh"

    `SIQ_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SIQ_ASSERT_SAME(a_load_when_free, i_clk, i_rst_n, w_cmd.load, !m_axis_tvalid || m_axis_tready)
    `SIQ_ASSERT_SAME(a_shift_on_greater, i_clk, i_rst_n, w_cmd.shift, w_sts.key_gt && w_sts.can_scan)

endmodule
